>>> src/mipds_pkg.sv
// Shared types, constants and helper functions of the mipmap downsampler.
`timescale 1ns / 1ps
package mipds_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_ALPHA_MODE   = 2'd2;

    localparam int CFG_W     = 13;    // widest register
    localparam int HGT_LIMIT = 4096;  // largest source height
    localparam int HGT_W     = 13;    // holds HGT_LIMIT
    localparam int ROW_W     = 12;    // row counter, 0 .. HGT_LIMIT-1

    // Pair sums: 17-bit colour fields, 9-bit alpha field
    localparam int COL_W   = 17;
    localparam int ALP_W   = 9;
    // 2x2 sums: colour up to 4*255*255, alpha up to 4*255
    localparam int SUM_W   = 18;
    localparam int DEN_W   = 10;
    localparam int LANES   = 3;
    localparam int Q_W     = 8;
    localparam int STEP_W  = 3;   // counts Q_W quotient steps

    // Horizontal pair sum as kept in the line memory (60 bits)
    typedef struct packed {
        logic [ALP_W-1:0] a;
        logic [COL_W-1:0] b;
        logic [COL_W-1:0] g;
        logic [COL_W-1:0] r;
    } pair_t;

    // Request into the divider
    typedef struct packed {
        logic                             start;
        logic [LANES-1:0][SUM_W-1:0]      num;
        logic [DEN_W-1:0]                 den;
        logic                             zero;
    } div_req_t;

    // Divider status
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // One colour channel's contribution: c*a when premultiplied, else c
    function automatic logic [COL_W-1:0] chan_contrib(
        input logic [7:0] c,
        input logic [7:0] a,
        input logic       premul
    );
        logic [15:0] prod;
        prod = 16'(c) * 16'(a);
        return premul ? COL_W'(prod) : COL_W'(c);
    endfunction

    // Packed contribution of one pixel
    function automatic pair_t pix_contrib(
        input logic [7:0] r,
        input logic [7:0] g,
        input logic [7:0] b,
        input logic [7:0] a,
        input logic       premul
    );
        pair_t p;
        p.r = chan_contrib(r, a, premul);
        p.g = chan_contrib(g, a, premul);
        p.b = chan_contrib(b, a, premul);
        p.a = ALP_W'(a);
        return p;
    endfunction

    // Field-wise sum of two contributions (no field overflows)
    function automatic pair_t pair_add(input pair_t x, input pair_t y);
        pair_t p;
        p.r = x.r + y.r;
        p.g = x.g + y.g;
        p.b = x.b + y.b;
        p.a = x.a + y.a;
        return p;
    endfunction

endpackage

>>> src/mipmap_downsample_2x2.sv
// Top level of the 2x2 box-filter mipmap downsampler.
// Source RGBA pixels of one level enter on the s_ channel in raster order
// (valid/ready); pixels of the half-size level leave on the m_ channel,
// m_end_of_image marking the last one. Output size is max(1, size/2); an odd
// last column or row is dropped, a size of 1 repeats the pixel.
// Configuration: cfg_we with cfg_addr/cfg_wdata writes image_width (0),
// image_height (1) or alpha_mode (2); any such write restarts the image.
// Pixels that make no result do not hold off input. A pixel that completes a
// 2x2 block holds off input until its result is loaded into the output register.
// Premultiplied mode: the line memory read and the sums, then the bit-serial
// divider (one quotient bit per cycle for each of the three colours), then the
// output register. Plain mode divides by four with a shift instead.
// A result waiting in the output register does not block input; only a
// second block result then waits until the receiver takes the first.
// Reset sets width and height to 1, premultiplied mode, and clears counters.
// The line memory needs no clearing: each entry is written on an even row
// before it is read on the following odd row.
`timescale 1ns / 1ps
module mipmap_downsample_2x2 #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_addr,
    input  logic [mipds_pkg::CFG_W-1:0]   cfg_wdata,
    // source pixels
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_in_red,
    input  logic [7:0]                    s_in_green,
    input  logic [7:0]                    s_in_blue,
    input  logic [7:0]                    s_in_alpha,
    // filtered pixels
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_out_red,
    output logic [7:0]                    m_out_green,
    output logic [7:0]                    m_out_blue,
    output logic [7:0]                    m_out_alpha,
    output logic                          m_end_of_image
);

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CNT_W      = $clog2(MAX_WIDTH);
    localparam int EW_W       = $clog2(MAX_WIDTH + 1);
    localparam int HW         = mipds_pkg::HGT_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    // Configuration registers
    logic [mipds_pkg::CFG_W-1:0] width_reg;
    logic [mipds_pkg::CFG_W-1:0] height_reg;
    logic                        mode_reg;

    // Position and held pixel
    logic [CNT_W-1:0]            col_reg;
    logic [mipds_pkg::ROW_W-1:0] row_reg;
    mipds_pkg::pair_t            held_reg;

    // Control
    logic [1:0]                  state_reg;
    logic [1:0]                  state_next;

    // Block in flight
    mipds_pkg::pair_t            pair_reg;
    logic                        upper_self_reg;
    logic                        eoi_reg;
    logic [7:0]                  alpha_reg;

    // Output register
    logic                        m_valid_reg;
    logic [7:0]                  red_reg;
    logic [7:0]                  green_reg;
    logic [7:0]                  blue_reg;
    logic [7:0]                  alpha_out_reg;
    logic                        eoi_out_reg;

    // Combinational
    logic [31:0]                 w_ext;
    logic [31:0]                 h_ext;
    logic [EW_W-1:0]             eff_w;
    logic [HW-1:0]               eff_h;
    logic [EW_W-1:0]             out_w;
    logic [HW-1:0]               out_h;
    logic                        w_one;
    logic                        h_one;
    logic                        accept;
    logic                        has_pair;
    logic                        emit;
    logic                        line_wr;
    logic [ADDR_W-1:0]           oc;
    logic [HW-1:0]               orow;
    logic                        eoi;
    logic [EW_W-1:0]             col_inc;
    logic [HW-1:0]               row_inc;
    mipds_pkg::pair_t            cur;
    mipds_pkg::pair_t            pair;
    mipds_pkg::pair_t            upper;
    mipds_pkg::pair_t            rd_data;
    logic [mipds_pkg::DEN_W-1:0] alpha_sum;
    logic                        out_load;
    mipds_pkg::div_req_t         div_req;
    mipds_pkg::div_stat_t        div_stat;
    logic [mipds_pkg::LANES-1:0][mipds_pkg::Q_W-1:0] quot;

    // Effective sizes: 0 acts as 1, clamp to the limits
    always_comb begin
        w_ext = 32'(width_reg);
        h_ext = 32'(height_reg);
        if (w_ext == 32'd0) begin
            eff_w = EW_W'(1);
        end else if (w_ext > 32'(MAX_WIDTH)) begin
            eff_w = EW_W'(MAX_WIDTH);
        end else begin
            eff_w = EW_W'(w_ext);
        end
        if (h_ext == 32'd0) begin
            eff_h = HW'(1);
        end else if (h_ext > 32'(mipds_pkg::HGT_LIMIT)) begin
            eff_h = HW'(mipds_pkg::HGT_LIMIT);
        end else begin
            eff_h = HW'(h_ext);
        end
        out_w = ((eff_w >> 1) == '0) ? EW_W'(1) : (eff_w >> 1);
        out_h = ((eff_h >> 1) == '0) ? HW'(1) : (eff_h >> 1);
        w_one = (eff_w == EW_W'(1));
        h_one = (eff_h == HW'(1));
    end

    // Pairing of the incoming pixel with the held one
    always_comb begin
        accept   = s_valid && s_ready;
        cur      = mipds_pkg::pix_contrib(s_in_red, s_in_green, s_in_blue,
                                          s_in_alpha, mode_reg);
        pair     = mipds_pkg::pair_add(w_one ? cur : held_reg, cur);
        has_pair = w_one || col_reg[0];
        emit     = has_pair && (h_one || row_reg[0]);
        line_wr  = accept && has_pair && !h_one && !row_reg[0];
        oc       = ADDR_W'(col_reg >> 1);
        orow     = h_one ? '0 : HW'(row_reg >> 1);
        eoi      = (EW_W'(oc) == out_w - 1'b1) && (orow == out_h - 1'b1);
        col_inc  = EW_W'(col_reg) + EW_W'(1);
        row_inc  = HW'(row_reg) + HW'(1);
    end

    mipds_line_mem #(
        .DEPTH  (LINE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_line_mem (
        .aclk    (aclk),
        .wr_en   (line_wr),
        .wr_addr (oc),
        .wr_data (pair),
        .rd_en   (accept && emit && !h_one),
        .rd_addr (oc),
        .rd_data (rd_data)
    );

    // Configuration writes, position counters and held pixel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= mipds_pkg::CFG_W'(1);
            height_reg <= mipds_pkg::CFG_W'(1);
            mode_reg   <= 1'b1;
            col_reg    <= '0;
            row_reg    <= '0;
            held_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                mipds_pkg::REG_IMAGE_WIDTH: begin
                    width_reg <= cfg_wdata;
                    col_reg   <= '0;
                    row_reg   <= '0;
                end
                mipds_pkg::REG_IMAGE_HEIGHT: begin
                    height_reg <= cfg_wdata;
                    col_reg    <= '0;
                    row_reg    <= '0;
                end
                mipds_pkg::REG_ALPHA_MODE: begin
                    mode_reg <= cfg_wdata[0];
                    col_reg  <= '0;
                    row_reg  <= '0;
                end
                default: begin
                end
            endcase
        end else if (accept) begin
            if (!w_one && !col_reg[0]) begin
                held_reg <= cur;
            end
            if (col_inc >= eff_w) begin
                col_reg <= '0;
                row_reg <= (row_inc >= eff_h) ? '0 : mipds_pkg::ROW_W'(row_inc);
            end else begin
                col_reg <= CNT_W'(col_inc);
            end
        end
    end

    // Sequencer: accept, form the 2x2 sums, divide (premultiplied mode only)
    assign out_load = (state_reg == ST_DIV) && (!mode_reg || div_stat.done)
                      && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && emit) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    // Block in flight
    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            pair_reg       <= pair;
            upper_self_reg <= h_one;
            eoi_reg        <= eoi;
        end
        if (state_reg == ST_LOAD) begin
            alpha_reg <= alpha_sum[mipds_pkg::DEN_W-1:2];
        end
    end

    // 2x2 sums and divider request; line memory data and pair_reg hold until
    // the result is loaded
    always_comb begin
        upper     = upper_self_reg ? pair_reg : rd_data;
        alpha_sum = mipds_pkg::DEN_W'(upper.a) + mipds_pkg::DEN_W'(pair_reg.a);
        div_req.start  = (state_reg == ST_LOAD) && mode_reg;
        div_req.num[0] = mipds_pkg::SUM_W'(upper.r) + mipds_pkg::SUM_W'(pair_reg.r);
        div_req.num[1] = mipds_pkg::SUM_W'(upper.g) + mipds_pkg::SUM_W'(pair_reg.g);
        div_req.num[2] = mipds_pkg::SUM_W'(upper.b) + mipds_pkg::SUM_W'(pair_reg.b);
        div_req.den    = alpha_sum;
        div_req.zero   = (alpha_sum == '0);
    end

    mipds_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .stat    (div_stat),
        .quot    (quot)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // plain mode: four byte sum fits DEN_W bits, floor of a quarter by shift
    always_ff @(posedge aclk) begin
        if (out_load) begin
            red_reg       <= mode_reg ? quot[0] : div_req.num[0][mipds_pkg::DEN_W-1:2];
            green_reg     <= mode_reg ? quot[1] : div_req.num[1][mipds_pkg::DEN_W-1:2];
            blue_reg      <= mode_reg ? quot[2] : div_req.num[2][mipds_pkg::DEN_W-1:2];
            alpha_out_reg <= alpha_reg;
            eoi_out_reg   <= eoi_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_red      = red_reg;
    assign m_out_green    = green_reg;
    assign m_out_blue     = blue_reg;
    assign m_out_alpha    = alpha_out_reg;
    assign m_end_of_image = eoi_out_reg;

endmodule

>>> src/mipds_line_mem.sv
// Line memory holding the upper-row pair sums, one entry per output column.
`timescale 1ns / 1ps
module mipds_line_mem #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  mipds_pkg::pair_t     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output mipds_pkg::pair_t     rd_data
);

    mipds_pkg::pair_t mem [DEPTH];
    mipds_pkg::pair_t rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/mipds_divider.sv
// Three-lane restoring divider, one quotient bit per lane per cycle.
`timescale 1ns / 1ps
module mipds_divider (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  mipds_pkg::div_req_t                             req,
    output mipds_pkg::div_stat_t                            stat,
    output logic [mipds_pkg::LANES-1:0][mipds_pkg::Q_W-1:0] quot
);

    logic [mipds_pkg::LANES-1:0][mipds_pkg::SUM_W-1:0] rem_reg;
    logic [mipds_pkg::LANES-1:0][mipds_pkg::Q_W-1:0]   q_reg;
    logic [mipds_pkg::SUM_W-1:0]                       dsh_reg;
    logic [mipds_pkg::STEP_W-1:0]                      step_reg;
    logic                                              zero_reg;
    logic                                              busy_reg;
    logic                                              done_reg;

    // Control: busy from a start until the last quotient step, done until the next start
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= mipds_pkg::STEP_W'(mipds_pkg::Q_W - 1);
        end else if (busy_reg) begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath: quotient is known to fit Q_W bits, so start at den << (Q_W-1)
    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg  <= req.num;
            q_reg    <= '0;
            zero_reg <= req.zero;
            dsh_reg  <= mipds_pkg::SUM_W'(req.den) << (mipds_pkg::Q_W - 1);
        end else if (busy_reg) begin
            for (int i = 0; i < mipds_pkg::LANES; i++) begin
                if (rem_reg[i] >= dsh_reg) begin
                    rem_reg[i] <= rem_reg[i] - dsh_reg;
                    q_reg[i]   <= {q_reg[i][mipds_pkg::Q_W-2:0], 1'b1};
                end else begin
                    q_reg[i]   <= {q_reg[i][mipds_pkg::Q_W-2:0], 1'b0};
                end
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    // Zero divisor gives zero
    always_comb begin
        for (int i = 0; i < mipds_pkg::LANES; i++) begin
            quot[i] = zero_reg ? '0 : q_reg[i];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the 2x2 box-filter mipmap downsampler.
`timescale 1ns / 1ps
module tb_top;

    localparam int          LINE_MAX      = 4096;       // MAX_WIDTH of the instance
    localparam int          RANDOM_PIXELS = 1000;
    localparam int          WIDE_W        = 301;        // odd: last column dropped
    localparam int          TALL_H        = 300;
    localparam int          DRAIN_CYCLES  = 24;         // lets a block still in flight finish
    localparam int          GAP_PCT       = 35;
    localparam longint      TIMEOUT_NS    = 10_000_000;
    localparam logic [1:0]  REG_UNUSED    = 2'd3;       // unmapped index, ignored

    // Source pixel, packed as alpha:blue:green:red
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgba_t;

    // Filtered pixel as seen on the m_ channel
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } mip_px_t;

    // Per-channel weighted sums of one or more pixels
    typedef struct {
        int unsigned r;
        int unsigned g;
        int unsigned b;
        int unsigned a;
    } box_sum_t;

    typedef enum int unsigned {MIX_ANY, MIX_SPARSE, MIX_BINARY} alpha_mix_e;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [1:0]                    cfg_addr = mipds_pkg::REG_IMAGE_WIDTH;
    logic [mipds_pkg::CFG_W-1:0]   cfg_wdata = '0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [7:0]                    s_in_red = '0;
    logic [7:0]                    s_in_green = '0;
    logic [7:0]                    s_in_blue = '0;
    logic [7:0]                    s_in_alpha = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [7:0]                    m_out_red;
    logic [7:0]                    m_out_green;
    logic [7:0]                    m_out_blue;
    logic [7:0]                    m_out_alpha;
    logic                          m_end_of_image;

    // Stimulus and expectations
    rgba_t                src_q[$];
    mip_px_t              want_q[$];
    bit                   gaps_on = 1'b1;
    int unsigned          mismatches = 0;
    int unsigned          results_seen = 0;

    // Shadow of the block's configuration and position
    logic [mipds_pkg::CFG_W-1:0] cur_width = mipds_pkg::CFG_W'(1);
    logic [mipds_pkg::CFG_W-1:0] cur_height = mipds_pkg::CFG_W'(1);
    logic                 cur_premul = 1'b1;
    int unsigned          col_pos = 0;
    int unsigned          row_pos = 0;
    rgba_t                held_px = '0;
    box_sum_t             upper_sums [LINE_MAX/2];

    mipmap_downsample_2x2 #(
        .MAX_WIDTH(LINE_MAX)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_red       (s_in_red),
        .s_in_green     (s_in_green),
        .s_in_blue      (s_in_blue),
        .s_in_alpha     (s_in_alpha),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_red      (m_out_red),
        .m_out_green    (m_out_green),
        .m_out_blue     (m_out_blue),
        .m_out_alpha    (m_out_alpha),
        .m_end_of_image (m_end_of_image)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Filter prediction
    // ------------------------------------------------------------------

    // Size register as the block uses it: 0 means 1, clipped at the limit
    function automatic int unsigned clamp_size(input logic [mipds_pkg::CFG_W-1:0] raw,
                                               input int unsigned limit);
        if (raw == 0) return 1;
        if (32'(raw) > limit) return limit;
        return 32'(raw);
    endfunction

    // Colours weighted by alpha in premultiplied mode
    function automatic box_sum_t weigh(input rgba_t px);
        box_sum_t s;
        s.a = 32'(px.alpha);
        s.r = cur_premul ? int'(px.red) * int'(px.alpha) : int'(px.red);
        s.g = cur_premul ? int'(px.green) * int'(px.alpha) : int'(px.green);
        s.b = cur_premul ? int'(px.blue) * int'(px.alpha) : int'(px.blue);
        return s;
    endfunction

    function automatic box_sum_t add_sums(input box_sum_t x, input box_sum_t y);
        box_sum_t s;
        s.r = x.r + y.r;
        s.g = x.g + y.g;
        s.b = x.b + y.b;
        s.a = x.a + y.a;
        return s;
    endfunction

    // Floor average of one colour over the 2x2 block
    function automatic logic [7:0] chan_avg(input int unsigned sum, input int unsigned asum);
        if (!cur_premul) return 8'(sum / 4);
        if (asum == 0) return 8'h00;
        return 8'(sum / asum);
    endfunction

    // Take one accepted source pixel; queue the filtered pixel it completes
    task automatic absorb_pixel(input rgba_t px);
        int unsigned w, h, ow, oh, oc, orow;
        box_sum_t    pair, upper, total;
        bit          has_pair, emit;
        mip_px_t     res;
        w = clamp_size(cur_width, LINE_MAX);
        h = clamp_size(cur_height, mipds_pkg::HGT_LIMIT);
        ow = (w / 2 != 0) ? w / 2 : 1;
        oh = (h / 2 != 0) ? h / 2 : 1;
        oc = 0;
        orow = 0;
        has_pair = 1'b0;
        emit = 1'b0;

        // horizontal pair: width 1 doubles the pixel
        if (w == 1) begin
            pair = add_sums(weigh(px), weigh(px));
            has_pair = 1'b1;
        end else if (col_pos[0]) begin
            pair = add_sums(weigh(held_px), weigh(px));
            oc = col_pos >> 1;
            has_pair = 1'b1;
        end else begin
            held_px = px;
        end

        // vertical pair: even rows park the pair sum, odd rows complete it
        if (has_pair) begin
            if (h == 1) begin
                upper = pair;
                emit = 1'b1;
            end else if (row_pos[0]) begin
                upper = upper_sums[oc];
                orow = row_pos >> 1;
                emit = 1'b1;
            end else begin
                upper_sums[oc] = pair;
            end
        end

        if (emit) begin
            total = add_sums(upper, pair);
            res.red   = chan_avg(total.r, total.a);
            res.green = chan_avg(total.g, total.a);
            res.blue  = chan_avg(total.b, total.a);
            res.alpha = 8'(total.a / 4);
            res.last  = (oc == ow - 1) && (orow == oh - 1);
            want_q.push_back(res);
        end

        // raster position, wrapping into the next image
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
    endtask

    // ------------------------------------------------------------------
    // Source driver
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : src_drive
        rgba_t next_px;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                absorb_pixel({s_in_alpha, s_in_blue, s_in_green, s_in_red});
            end
            if (!s_valid || s_ready) begin
                if (src_q.size() != 0 && !(gaps_on && $urandom_range(99) < GAP_PCT)) begin
                    next_px = src_q.pop_front();
                    s_valid <= 1'b1;
                    s_in_red <= next_px.red;
                    s_in_green <= next_px.green;
                    s_in_blue <= next_px.blue;
                    s_in_alpha <= next_px.alpha;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    task automatic flag_result(input string what, input mip_px_t want, input mip_px_t seen);
        mismatches++;
        if (mismatches <= 10) begin
            $display("result %0d %s: expected rgba %h %h %h %h eoi %b, got rgba %h %h %h %h eoi %b",
                     results_seen, what, want.red, want.green, want.blue, want.alpha, want.last,
                     seen.red, seen.green, seen.blue, seen.alpha, seen.last);
        end
    endtask

    always @(posedge aclk) begin : res_check
        mip_px_t seen;
        mip_px_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                seen = {m_out_red, m_out_green, m_out_blue, m_out_alpha, m_end_of_image};
                if (want_q.size() == 0) begin
                    flag_result("unexpected", '0, seen);
                end else begin
                    want = want_q.pop_front();
                    if (seen !== want) flag_result("wrong", want, seen);
                end
                results_seen++;
            end
            m_ready <= !(gaps_on && $urandom_range(99) < GAP_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Sequencing helpers
    // ------------------------------------------------------------------

    // Wait until every request is taken and every result is in, then let
    // in-flight pixels that make no result finish
    task automatic settle();
        do @(negedge aclk); while (src_q.size() != 0 || s_valid || want_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int unsigned value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= mipds_pkg::CFG_W'(value);
        @(posedge aclk);
        cfg_we <= 1'b0;
        // any mapped register restarts the image
        case (idx)
            mipds_pkg::REG_IMAGE_WIDTH: begin
                cur_width = mipds_pkg::CFG_W'(value);
                col_pos = 0;
                row_pos = 0;
            end
            mipds_pkg::REG_IMAGE_HEIGHT: begin
                cur_height = mipds_pkg::CFG_W'(value);
                col_pos = 0;
                row_pos = 0;
            end
            mipds_pkg::REG_ALPHA_MODE: begin
                cur_premul = value[0];
                col_pos = 0;
                row_pos = 0;
            end
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic setup_image(input int unsigned w, input int unsigned h, input bit premul);
        write_reg(mipds_pkg::REG_IMAGE_WIDTH, w);
        write_reg(mipds_pkg::REG_IMAGE_HEIGHT, h);
        write_reg(mipds_pkg::REG_ALPHA_MODE, 32'(premul));
    endtask

    function automatic rgba_t rand_pixel(input alpha_mix_e mix);
        rgba_t p;
        p = $urandom;
        case (mix)
            MIX_SPARSE: if ($urandom_range(99) < 60) p.alpha = 8'h00;
            MIX_BINARY: p.alpha = $urandom_range(1) ? 8'hFF : 8'h00;
            default: ;
        endcase
        // saturated or black colour now and then
        if ($urandom_range(9) == 0) p[23:0] = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned w, h, n, pause_at, phase, random_px, i;
        alpha_mix_e  mix;

        aresetn = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: 1x1 premultiplied, every pixel is a whole image
        src_q.push_back(32'hFF_FF_FF_FF);
        src_q.push_back(32'h00_01_A5_5A);    // zero alpha sum
        src_q.push_back(32'h01_FE_7F_80);
        settle();

        // 3x3 plain: one block, odd column and row dropped
        setup_image(3, 3, 1'b0);
        src_q.push_back(32'hFF_FF_FF_FF);
        src_q.push_back(32'h00_00_00_00);
        src_q.push_back(32'hAA_AA_AA_AA);
        src_q.push_back(32'h55_55_55_55);
        src_q.push_back(32'hFF_FF_FF_FF);
        src_q.push_back(32'h12_12_12_12);
        src_q.push_back(32'h34_34_34_34);
        src_q.push_back(32'h56_56_56_56);
        src_q.push_back(32'h78_78_78_78);
        settle();

        // zero sizes act as 1
        setup_image(0, 0, 1'b0);
        src_q.push_back(32'h12_34_56_78);
        settle();

        // 2x2 premultiplied, restarted by a mode write partway through
        setup_image(2, 2, 1'b1);
        src_q.push_back(32'h80_11_22_33);
        src_q.push_back(32'h40_44_55_66);
        src_q.push_back(32'hFF_77_88_99);
        settle();
        write_reg(mipds_pkg::REG_ALPHA_MODE, 1);
        src_q.push_back(32'hFF_FF_00_FF);
        src_q.push_back(32'h00_FF_FF_FF);
        src_q.push_back(32'h80_00_FF_40);
        src_q.push_back(32'h01_FF_01_FF);
        settle();

        // wide image, two rows; sender holds off midway through the second row
        mix = alpha_mix_e'($urandom_range(2));
        setup_image(WIDE_W, 2, 1'($urandom_range(1)));
        for (i = 0; i < 2 * WIDE_W; i++) begin
            if (i == 3 * WIDE_W / 2) settle();
            src_q.push_back(rand_pixel(mix));
        end
        settle();

        // tall image, one column, no idling; two extra pixels wrap around
        gaps_on = 1'b0;
        mix = alpha_mix_e'($urandom_range(2));
        setup_image(0, TALL_H, 1'b1);
        for (i = 0; i < TALL_H + 2; i++) src_q.push_back(rand_pixel(mix));
        settle();
        gaps_on = 1'b1;

        // random small images, mostly whole images, sometimes with a partial tail
        phase = 0;
        random_px = 0;
        while (random_px < RANDOM_PIXELS) begin
            n = $urandom_range(99);
            if (n < 75) w = $urandom_range(8, 1);
            else if (n < 95) w = $urandom_range(40, 9);
            else w = $urandom_range(130, 41);
            h = (w > 40) ? $urandom_range(4, 1) : $urandom_range(8, 1);
            gaps_on = !(phase >= 4 && phase < 8);
            mix = alpha_mix_e'($urandom_range(2));
            setup_image((w == 1 && $urandom_range(1)) ? 0 : w,
                        (h == 1 && $urandom_range(1)) ? 0 : h, 1'($urandom_range(1)));

            n = ((w * h > 160) ? 1 : $urandom_range(3, 1)) * w * h;
            if ($urandom_range(2) == 0) n += $urandom_range(w * h - 1, 0);
            pause_at = (n > 1 && $urandom_range(5) == 0) ? $urandom_range(n - 1, 1) : n;

            for (i = 0; i < n; i++) begin
                // idle point: unmapped write must not restart, mode write must
                if (i == pause_at) begin
                    settle();
                    if ($urandom_range(1)) write_reg(REG_UNUSED, $urandom);
                    else write_reg(mipds_pkg::REG_ALPHA_MODE, $urandom_range(1));
                end
                src_q.push_back(rand_pixel(mix));
            end
            random_px += n;
            settle();
            phase++;
        end

        if (mismatches == 0 && want_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> filelist.f
src/mipds_pkg.sv
src/mipds_line_mem.sv
src/mipds_divider.sv
src/mipmap_downsample_2x2.sv
bench/tb_top.sv
